[src/euler_ode_step_refinement_top_defines.svh]
// Assertion macros shared by the checker of the Euler refinement block.
// No dependencies; included by the checker file.
`ifndef EULER_ODE_STEP_REFINEMENT_TOP_DEFINES_SVH
`define EULER_ODE_STEP_REFINEMENT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EOSR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("euler refinement check failed");

// Next-cycle implication, disabled while reset is asserted.
`define EOSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("euler refinement check failed");

`endif

[src/eosr_pkg.sv]
// Shared constants of the Euler step refinement block: stream widths and
// configuration register indexes. No dependencies.
package eosr_pkg;
    localparam int IN_W   = 328;
    localparam int OUT_W  = 136;
    localparam int IDX_W  = 8;

    localparam logic [IDX_W-1:0] REG_ACCURACY    = 8'd0;
    localparam logic [IDX_W-1:0] REG_EULER_STEPS = 8'd1;
    localparam logic [IDX_W-1:0] REG_START_VALUE = 8'd2;
    localparam logic [IDX_W-1:0] REG_ROUND_LIMIT = 8'd3;
endpackage

[src/euler_ode_step_refinement_top.sv]
// Forward Euler integration with step halving, in saturating signed fixed point.
// Depends on eosr_pkg. Holds the sequencer and the shared multiply/divide unit.
//
// Usage:
// A request on s_axis carries one parameter set; the block integrates it,
// repeatedly halving the step until the result converges or the round limit
// is reached, then presents one result request on m_axis.
// The configuration channel (i_cfg_*) is always ready and must only be
// written while the block is idle.
// s_axis_tready is high only while the sequencer is idle, so one request is
// worked on at a time. The result sits in an output register, so a new
// request is taken while the previous result still waits on m_axis_tready.
// One shared unit does every multiply (four 32x32 partial products) and
// divide (one quotient bit per cycle). A request whose round count is
// already at the limit passes from the round state straight to the done
// state and on to the output register.
// Reset clears the control state and loads the register reset values.
// A stalled receiver holds the result and its payload stable; the sequencer
// waits with its next result until the output register is free.
module euler_ode_step_refinement_top #(
    parameter int FRAC_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [eosr_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [63:0]               i_cfg_data,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // coef_a, coef_b, coef_c, step_in, prev_value, round_in, one zero pad bit
    input  logic [eosr_pkg::IN_W-1:0] s_axis_tdata,
    // prev_infinite
    input  logic                      s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // step_out, value_out, round_out, one zero pad bit
    output logic [eosr_pkg::OUT_W-1:0] m_axis_tdata,
    // status
    output logic                      m_axis_tuser
);
    import eosr_pkg::*;

    localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;
    localparam int SH_L = (FRAC_BITS >= 32) ? FRAC_BITS - 32 : 0;
    localparam int SH_R = (FRAC_BITS < 32) ? 32 - FRAC_BITS : 0;

    typedef enum logic [3:0] {
        S_IDLE, S_ROUND, S_STEP, S_OP, S_WAIT, S_CHECK, S_RATIO, S_NEXT, S_DONE
    } t_state;

    typedef enum logic [2:0] {U_IDLE, U_MUL, U_DIV, U_FIN} t_ustate;

    // Micro-step codes of one Euler step.
    localparam logic [3:0] PC_M_AT  = 4'd0;
    localparam logic [3:0] PC_M_Y1  = 4'd1;
    localparam logic [3:0] PC_M_Y2  = 4'd2;
    localparam logic [3:0] PC_D_B   = 4'd3;
    localparam logic [3:0] PC_SUB   = 4'd4;
    localparam logic [3:0] PC_D_C   = 4'd5;
    localparam logic [3:0] PC_M_T   = 4'd6;
    localparam logic [3:0] PC_ADD   = 4'd7;
    localparam logic [3:0] PC_M_S   = 4'd8;
    localparam logic [3:0] PC_Y     = 4'd9;
    localparam logic [3:0] PC_RATIO = 4'd10;

    function automatic logic is_inf(input logic signed [63:0] x);
        return (x == Q_MAX) || (x == Q_MIN);
    endfunction

    function automatic logic [63:0] mag_of(input logic signed [63:0] x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic signed [63:0] from_mag(input logic [63:0] m, input logic neg);
        logic signed [63:0] r;
        if (m[63]) r = neg ? Q_MIN : Q_MAX;
        else       r = neg ? -$signed(m) : $signed(m);
        return r;
    endfunction

    function automatic logic signed [63:0] add_q(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [63:0] s;
        logic signed [63:0] r;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) r = a[63] ? Q_MIN : Q_MAX;
        else r = s;
        return r;
    endfunction

    function automatic logic signed [63:0] sub_q(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [63:0] s;
        logic signed [63:0] r;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63]) r = a[63] ? Q_MIN : Q_MAX;
        else r = s;
        return r;
    endfunction

    // Configuration registers.
    logic [31:0]        r_accuracy;
    logic [15:0]        r_esteps;
    logic signed [63:0] r_start;
    logic [7:0]         r_limit;

    // Sequencer registers.
    t_state             r_state;
    logic [3:0]         r_pc;
    logic signed [63:0] r_a, r_b, r_c, r_prev, r_y, r_t, r_acc, r_tmp;
    logic [62:0]        r_step;
    logic               r_prev_inf;
    logic [7:0]         r_round;
    logic [16:0]        r_n;
    logic               r_status;
    logic               r_ovalid;
    logic [OUT_W-1:0]   r_odata;
    logic               r_ouser;

    // Shared unit registers.
    t_ustate            r_ustate;
    logic               r_ustart, r_udiv, r_udone, r_neg;
    logic signed [63:0] r_ua, r_ub, r_ures;
    logic [63:0]        r_ma, r_mb, r_pp, r_quo;
    logic [127:0]       r_prod;
    logic [64:0]        r_rem;
    logic [5:0]         r_ucnt;

    logic [63:0] acc_q, na, nb, hi, mul_mag;
    logic [64:0] rs;
    logic [1:0]  pp_pos;
    logic        div_sat;

    always_comb begin
        if (FRAC_BITS >= 32) acc_q = 64'(r_accuracy) << SH_L;
        else                 acc_q = 64'(r_accuracy) >> SH_R;
        na      = mag_of(r_ua);
        nb      = mag_of(r_ub);
        hi      = na >> (64 - FRAC_BITS);
        div_sat = hi >= nb;
        rs      = {r_rem[63:0], r_quo[63]};
        pp_pos  = {1'b0, r_ucnt[2]} + {1'b0, r_ucnt[1]};
        mul_mag = (|r_prod[127:63+FRAC_BITS]) ? '1 : {1'b0, r_prod[62+FRAC_BITS:FRAC_BITS]};
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accuracy <= 32'd42950;
            r_esteps   <= 16'd100;
            r_start    <= '0;
            r_limit    <= 8'd10;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ACCURACY:    r_accuracy <= i_cfg_data[31:0];
                REG_EULER_STEPS: r_esteps   <= i_cfg_data[15:0];
                REG_START_VALUE: r_start    <= $signed(i_cfg_data);
                REG_ROUND_LIMIT: r_limit    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_ustart <= 1'b0;
            r_pc     <= PC_M_AT;
        end else begin
            // The done state handles the output register itself.
            if (r_ovalid && m_axis_tready && r_state != S_DONE) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_a        <= $signed(s_axis_tdata[63:0]);
                        r_b        <= $signed(s_axis_tdata[127:64]);
                        r_c        <= $signed(s_axis_tdata[191:128]);
                        r_step     <= s_axis_tdata[254:192];
                        r_prev     <= $signed(s_axis_tdata[318:255]);
                        r_prev_inf <= s_axis_tuser || is_inf($signed(s_axis_tdata[318:255]));
                        r_round    <= s_axis_tdata[326:319];
                        r_state    <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    if (r_round >= r_limit) begin
                        r_status <= 1'b1;
                        r_state  <= S_DONE;
                    end else begin
                        r_y     <= r_start;
                        r_t     <= '0;
                        r_n     <= '0;
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (r_n > {1'b0, r_esteps} || is_inf(r_y)) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_t     <= add_q(r_t, $signed({1'b0, r_step}));
                        r_pc    <= PC_M_AT;
                        r_state <= S_OP;
                    end
                end
                S_OP: begin
                    case (r_pc)
                        PC_M_AT: begin
                            r_ua <= r_a; r_ub <= r_t; r_udiv <= 1'b0;
                            r_ustart <= 1'b1; r_state <= S_WAIT;
                        end
                        PC_M_Y1, PC_M_Y2: begin
                            r_ua <= r_acc; r_ub <= r_y; r_udiv <= 1'b0;
                            r_ustart <= 1'b1; r_state <= S_WAIT;
                        end
                        PC_D_B: begin
                            r_ua <= r_b; r_ub <= r_t; r_udiv <= 1'b1;
                            r_ustart <= 1'b1; r_state <= S_WAIT;
                        end
                        PC_D_C: begin
                            r_ua <= r_c; r_ub <= r_t; r_udiv <= 1'b1;
                            r_ustart <= 1'b1; r_state <= S_WAIT;
                        end
                        PC_M_T: begin
                            r_ua <= r_tmp; r_ub <= r_t; r_udiv <= 1'b0;
                            r_ustart <= 1'b1; r_state <= S_WAIT;
                        end
                        PC_M_S: begin
                            r_ua <= $signed({1'b0, r_step}); r_ub <= r_acc; r_udiv <= 1'b0;
                            r_ustart <= 1'b1; r_state <= S_WAIT;
                        end
                        PC_SUB: begin
                            r_acc <= sub_q(r_acc, r_tmp);
                            r_pc  <= r_pc + 4'd1;
                        end
                        PC_ADD: begin
                            r_acc <= add_q(r_acc, r_tmp);
                            r_pc  <= r_pc + 4'd1;
                        end
                        default: begin
                            r_y     <= add_q(r_y, r_tmp);
                            r_n     <= r_n + 17'd1;
                            r_state <= S_STEP;
                        end
                    endcase
                end
                S_WAIT: begin
                    r_ustart <= 1'b0;
                    if (r_udone) begin
                        case (r_pc)
                            PC_M_AT, PC_M_Y1, PC_M_Y2, PC_RATIO: r_acc <= r_ures;
                            default: r_tmp <= r_ures;
                        endcase
                        if (r_pc == PC_RATIO) begin
                            r_state <= S_RATIO;
                        end else begin
                            r_pc    <= r_pc + 4'd1;
                            r_state <= S_OP;
                        end
                    end
                end
                S_CHECK: begin
                    if (!is_inf(r_y) && !r_prev_inf && r_y != 64'sd0) begin
                        r_ua     <= sub_q(r_y, r_prev);
                        r_ub     <= r_y;
                        r_udiv   <= 1'b1;
                        r_ustart <= 1'b1;
                        r_pc     <= PC_RATIO;
                        r_state  <= S_WAIT;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_RATIO: begin
                    if (mag_of(r_acc) <= acc_q) begin
                        r_status <= 1'b0;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_round    <= r_round + 8'd1;
                    r_step     <= r_step >> 1;
                    r_prev     <= r_y;
                    r_prev_inf <= is_inf(r_y);
                    r_state    <= S_ROUND;
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {1'b0, r_round, r_prev, r_step};
                        r_ouser  <= r_status;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Shared multiply/divide unit. Multiplies sum four registered 32x32
    // partial products; divides produce one quotient bit a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ustate <= U_IDLE;
            r_udone  <= 1'b0;
        end else begin
            unique case (r_ustate)
                U_IDLE: begin
                    if (r_ustart) begin
                        r_neg  <= r_ua[63] != r_ub[63];
                        r_ucnt <= '0;
                        if (!r_udiv) begin
                            r_ma     <= na;
                            r_mb     <= nb;
                            r_prod   <= '0;
                            r_udone  <= 1'b0;
                            r_ustate <= U_MUL;
                        end else if (nb == 64'd0) begin
                            r_ures  <= (r_ua == 64'sd0) ? 64'sd0 : (r_ua[63] ? Q_MIN : Q_MAX);
                            r_udone <= 1'b1;
                        end else if (div_sat) begin
                            r_ures  <= (r_ua[63] != r_ub[63]) ? Q_MIN : Q_MAX;
                            r_udone <= 1'b1;
                        end else begin
                            r_mb     <= nb;
                            r_rem    <= {1'b0, hi};
                            r_quo    <= na << FRAC_BITS;
                            r_udone  <= 1'b0;
                            r_ustate <= U_DIV;
                        end
                    end else begin
                        r_udone <= 1'b0;
                    end
                end
                U_MUL: begin
                    if (!r_ucnt[0]) begin
                        r_pp <= (r_ucnt[2] ? 64'(r_ma[63:32]) : 64'(r_ma[31:0]))
                              * (r_ucnt[1] ? 64'(r_mb[63:32]) : 64'(r_mb[31:0]));
                    end else begin
                        r_prod <= r_prod + (128'(r_pp) << {pp_pos, 5'b0});
                    end
                    r_ucnt <= r_ucnt + 6'd1;
                    if (r_ucnt == 6'd7) r_ustate <= U_FIN;
                end
                U_DIV: begin
                    if (rs >= {1'b0, r_mb}) begin
                        r_rem <= rs - {1'b0, r_mb};
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= rs;
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                    r_ucnt <= r_ucnt + 6'd1;
                    if (r_ucnt == 6'd63) r_ustate <= U_FIN;
                end
                U_FIN: begin
                    r_ures   <= r_udiv ? from_mag(r_quo, r_neg) : from_mag(mul_mag, r_neg);
                    r_udone  <= 1'b1;
                    r_ustate <= U_IDLE;
                end
                default: r_ustate <= U_IDLE;
            endcase
        end
    end
endmodule

[src/eosr_checker.sv]
// Port-level checker for the Euler refinement top level, with its bind.
// Depends on eosr_pkg and euler_ode_step_refinement_top_defines.svh.
`include "euler_ode_step_refinement_top_defines.svh"

module eosr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [eosr_pkg::OUT_W-1:0] m_axis_tdata
);
    import eosr_pkg::*;

    // An accepted request keeps the block busy for at least the next cycle.
    `EOSR_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A new result only appears at the end of a busy period.
    `EOSR_ASSERT_IMPLY(a_result_after_busy, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(!s_axis_tready))
    // A stalled result holds its payload.
    `EOSR_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind euler_ode_step_refinement_top eosr_checker u_eosr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
